// ===== rtl/core/bounded_ordered_list_engine_assert.svh =====
// Assertion macros for the bounded ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define BOLE_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("bole assertion failed");
`define BOLE_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("bole assertion failed");
`else
`define BOLE_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define BOLE_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

// ===== rtl/core/bole_pkg.sv =====
// Shared types and codes of the bounded ordered list engine.
`default_nettype none
package bole_pkg;
	localparam int MODE_W  = 3;
	localparam int DATA_W  = 32;
	localparam int POS_W   = 5;
	localparam int STAT_W  = 3;
	localparam int CNT_W   = 5;

	localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
	localparam logic [STAT_W-1:0] ST_RANGE  = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
	localparam logic [STAT_W-1:0] ST_ABSENT = 3'd4;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic load_new;
		logic shift_up;
		logic shift_down;
	} cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/bole_ifs.sv =====
// Request and response channel interfaces of the bounded ordered list engine.
`default_nettype none
interface bole_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        mode;
	logic signed [31:0] value;
	logic [4:0]        position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink (input valid, input mode, input value, input position, output ready);
endinterface

interface bole_rsp_if;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic signed [31:0] found_value;
	logic [4:0]        count;

	modport source (output valid, output status, output found_value, output count, input ready);
	modport sink (input valid, input status, input found_value, input count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bole_cell.sv =====
// One list cell: holds an entry, compares it, and shifts with its neighbors.
`default_nettype none
module bole_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cmp_en,
	input  wire                     live,
	input  wire signed [31:0]       cmp_value,
	input  wire signed [31:0]       new_value,
	input  bole_pkg::cell_ctl_t     ctl,
	input  wire signed [31:0]       left_value,
	input  wire signed [31:0]       right_value,
	input  wire                     prefix_in,
	output logic signed [31:0]      value,
	output logic                    prefix_out
);
	import bole_pkg::*;

	data_t value_q;
	logic  match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (cmp_en) begin
			match_q <= live && (value_q == cmp_value);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_new) begin
			value_q <= new_value;
		end else if (ctl.shift_up) begin
			value_q <= left_value;
		end else if (ctl.shift_down && prefix_out) begin
			value_q <= right_value;
		end
	end

	assign prefix_out = prefix_in | match_q;
	assign value      = value_q;
endmodule
`default_nettype wire

// ===== rtl/core/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine: a chain of DEPTH entry cells.
// Keeps an ordered list of up to DEPTH signed 32-bit values in a row of cells.
// A request transaction (insert front, append, insert at position, delete
// value, search value): when it is accepted each cell compares its entry with
// the request value into a register; once the response register is free, an
// OR chain through the cells finds the first match, and the cells after the
// insert place shift up, or on a delete the cells from the first match on
// shift down, by one place at once. One response follows each request; a new
// request waits until the previous one is done, also while a finished response
// holds the response register. No clearing is needed after reset.
`default_nettype none
module bounded_ordered_list_engine #(
	parameter int DEPTH = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	bole_req_if.sink   req,
	bole_rsp_if.source rsp
);
	import bole_pkg::*;

	`include "bounded_ordered_list_engine_assert.svh"

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > POS_W) ? CW : POS_W;

	logic              busy_q;
	logic [MODE_W-1:0] mode_s1;
	data_t             value_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [CW-1:0]     count_q;
	logic              rsp_valid_q;
	logic [STAT_W-1:0] status_q;
	data_t             found_q;
	logic [CNT_W-1:0]  rsp_count_q;

	logic              accept;
	logic              done;
	logic              is_ins;
	logic              is_find;
	logic              full;
	logic              empty;
	logic              any_match;
	logic [IW-1:0]     idx;
	logic              ins_ok;
	logic              del_ok;
	logic [STAT_W-1:0] status_d;
	data_t             found_d;
	logic [CW-1:0]     count_d;

	data_t             cell_val [DEPTH];
	logic [DEPTH:0]    prefix;

	assign accept    = req.valid && req.ready;
	assign req.ready = !busy_q;
	assign done      = busy_q && (!rsp_valid_q || rsp.ready);

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign any_match = prefix[DEPTH];

	always_comb begin
		is_ins   = 1'b0;
		is_find  = 1'b0;
		idx      = '0;
		status_d = ST_OK;
		case (mode_s1)
			MODE_INS_FRONT: begin
				is_ins = 1'b1;
				idx    = '0;
			end
			MODE_APPEND: begin
				is_ins = 1'b1;
				idx    = IW'(count_q);
			end
			MODE_INS_POS: begin
				is_ins = 1'b1;
				idx    = IW'(pos_s1);
			end
			MODE_DELETE, MODE_SEARCH: begin
				is_find = 1'b1;
			end
			default: begin
				is_ins  = 1'b0;
				is_find = 1'b0;
			end
		endcase
		if (is_ins) begin
			if (full) begin
				status_d = ST_FULL;
			end else if (idx > IW'(count_q)) begin
				status_d = ST_RANGE;
			end
		end else if (is_find) begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else if (!any_match) begin
				status_d = ST_ABSENT;
			end
		end
		ins_ok  = done && is_ins && (status_d == ST_OK);
		del_ok  = done && (mode_s1 == MODE_DELETE) && (status_d == ST_OK);
		found_d = (is_find && (status_d == ST_OK)) ? value_s1 : '0;
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + 1'b1;
		end else if (del_ok) begin
			count_d = count_q - 1'b1;
		end
	end

	assign prefix[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t   ctl;
		data_t       left_v;
		data_t       right_v;

		assign ctl.load_new   = ins_ok && (idx == IW'(i));
		assign ctl.shift_up   = ins_ok && (idx < IW'(i));
		assign ctl.shift_down = del_ok;
		assign left_v  = (i == 0) ? value_s1 : cell_val[(i == 0) ? 0 : i - 1];
		assign right_v = (i == DEPTH - 1) ? value_s1 : cell_val[(i == DEPTH - 1) ? i : i + 1];

		bole_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmp_en      (accept),
			.live        (CW'(i) < count_q),
			.cmp_value   (req.value),
			.new_value   (value_s1),
			.ctl         (ctl),
			.left_value  (left_v),
			.right_value (right_v),
			.prefix_in   (prefix[i]),
			.value       (cell_val[i]),
			.prefix_out  (prefix[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= req.mode;
			value_s1 <= req.value;
			pos_s1   <= req.position;
		end
		if (done) begin
			status_q    <= status_d;
			found_q     <= found_d;
			rsp_count_q <= CNT_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found_value = found_q;
	assign rsp.count       = rsp_count_q;

	`BOLE_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`BOLE_ASSERT_NEXT(a_ins_grows, clk, arst_n, ins_ok, count_q == $past(count_q) + 1'b1)
	`BOLE_ASSERT_NEXT(a_del_value, clk, arst_n, del_ok, rsp.found_value == $past(value_s1))
	`BOLE_ASSERT_IMPLY(a_no_accept_busy, clk, arst_n, busy_q, !accept)
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the bounded ordered list engine: directed table, random phases, self-checking.
module tb;
	import bole_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int RANDOM_ITEMS = 1200;
	localparam int CYCLE_LIMIT = 500_000;
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 250;
	localparam int REPORT_CAP = 30;

	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	localparam data_t VAL_MIN = 32'sh8000_0000;
	localparam data_t VAL_MAX = 32'sh7fff_ffff;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_e;
	typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		data_t             found;
		logic [CNT_W-1:0]  count;
	} list_result_t;

	typedef struct {
		logic [MODE_W-1:0] mode;
		data_t             value;
		logic [POS_W-1:0]  pos;
		int                reps;
		bit                typed;
		list_result_t      want;
	} list_stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bole_req_if req_if();
	bole_rsp_if rsp_if();

	bounded_ordered_list_engine #(
		.DEPTH(LIST_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #2 clk = ~clk;

	data_t        list_mem [LIST_DEPTH];
	int           list_len = 0;
	list_result_t pending_results [$];
	int           accepted_reqs = 0;
	int           fail_cnt = 0;
	int           status_hits [5] = '{default: 0};
	int           peak_len = 0;
	int           burst_left = 0;
	int           cycle_cnt = 0;
	bit           in_phase = 1'b0;

	list_stim_t dir_plan [19] = '{
		'{MODE_SEARCH,    32'sd0,  5'd0,  1, 1'b1, '{ST_EMPTY,  32'sd0,  5'd0}},
		'{MODE_DELETE,    -32'sd1, 5'd0,  1, 1'b1, '{ST_EMPTY,  32'sd0,  5'd0}},
		'{MODE_INS_POS,   32'sd1,  5'd1,  1, 1'b1, '{ST_RANGE,  32'sd0,  5'd0}},
		'{MODE_INS_POS,   VAL_MIN, 5'd0,  1, 1'b1, '{ST_OK,     32'sd0,  5'd1}},
		'{MODE_APPEND,    VAL_MAX, 5'd0,  1, 1'b1, '{ST_OK,     32'sd0,  5'd2}},
		'{MODE_INS_FRONT, -32'sd1, 5'd0,  1, 1'b1, '{ST_OK,     32'sd0,  5'd3}},
		'{MODE_INS_POS,   32'sd7,  5'd3,  1, 1'b1, '{ST_OK,     32'sd0,  5'd4}},
		'{MODE_APPEND,    32'sd7,  5'd0,  1, 1'b1, '{ST_OK,     32'sd0,  5'd5}},
		'{MODE_INS_POS,   32'sd7,  5'd31, 1, 1'b1, '{ST_RANGE,  32'sd0,  5'd5}},
		'{MODE_UNUSED_HI, -32'sd1, 5'd31, 1, 1'b1, '{ST_OK,     32'sd0,  5'd5}},
		'{MODE_DELETE,    32'sd7,  5'd0,  1, 1'b1, '{ST_OK,     32'sd7,  5'd4}},
		'{MODE_SEARCH,    VAL_MAX, 5'd0,  1, 1'b1, '{ST_OK,     VAL_MAX, 5'd4}},
		'{MODE_SEARCH,    32'sd0,  5'd0,  1, 1'b1, '{ST_ABSENT, 32'sd0,  5'd4}},
		'{MODE_APPEND,    32'sd100, 5'd0, 12, 1'b0, '{ST_OK,    32'sd0,  5'd0}},
		'{MODE_INS_FRONT, 32'sd3,  5'd0,  1, 1'b1, '{ST_FULL,   32'sd0,  5'd16}},
		'{MODE_APPEND,    32'sd3,  5'd0,  1, 1'b1, '{ST_FULL,   32'sd0,  5'd16}},
		'{MODE_INS_POS,   32'sd3,  5'd20, 1, 1'b1, '{ST_FULL,   32'sd0,  5'd16}},
		'{MODE_DELETE,    VAL_MIN, 5'd0,  1, 1'b1, '{ST_OK,     VAL_MIN, 5'd15}},
		'{MODE_DELETE,    32'sd0,  5'd0,  1, 1'b1, '{ST_ABSENT, 32'sd0,  5'd15}}
	};

	function automatic list_result_t apply_list_op(input logic [MODE_W-1:0] mode, input data_t value,
			input logic [POS_W-1:0] pos);
		list_result_t r;
		int slot;
		int hit;
		r = '{ST_OK, 32'sd0, 5'd0};
		hit = -1;
		case (mode)
			MODE_INS_FRONT, MODE_APPEND, MODE_INS_POS: begin
				slot = (mode == MODE_INS_FRONT) ? 0 : (mode == MODE_APPEND) ? list_len : int'(pos);
				if (list_len >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else if (slot > list_len) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = list_len; i > slot; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[slot] = value;
					list_len++;
				end
			end
			MODE_DELETE, MODE_SEARCH: begin
				for (int i = 0; i < list_len; i++)
					if (hit < 0 && list_mem[i] == value)
						hit = i;
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (hit < 0) begin
					r.status = ST_ABSENT;
				end else begin
					r.found = list_mem[hit];
					if (mode == MODE_DELETE) begin
						for (int i = hit; i + 1 < list_len; i++)
							list_mem[i] = list_mem[i+1];
						list_len--;
					end
				end
			end
			default: ;
		endcase
		r.count = 5'(list_len);
		return r;
	endfunction

	function automatic data_t pick_value(input bit want_hit);
		if (want_hit && list_len > 0 && $urandom_range(0, 99) < 70)
			return list_mem[$urandom_range(0, list_len - 1)];
		case ($urandom_range(0, 3))
			0: return data_t'(int'($urandom_range(0, 8)) - 4);
			1: begin
				case ($urandom_range(0, 3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return data_t'($urandom);
		endcase
	endfunction

	task automatic pace_sender();
		if (burst_left == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	task automatic push_request(input logic [MODE_W-1:0] mode, input data_t value,
			input logic [POS_W-1:0] pos, input bit typed, input list_result_t want);
		list_result_t predicted;
		req_if.valid <= 1'b1;
		req_if.mode <= mode;
		req_if.value <= value;
		req_if.position <= pos;
		@(posedge clk);
		while (req_if.ready !== 1'b1)
			@(posedge clk);
		predicted = apply_list_op(mode, value, pos);
		pending_results.push_back(typed ? want : predicted);
		accepted_reqs++;
		if (list_len > peak_len)
			peak_len = list_len;
	endtask

	task automatic wait_for_results();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input phase_kind_e kind, input int n);
		logic [MODE_W-1:0] mode;
		data_t value;
		logic [POS_W-1:0] pos;
		int roll;
		int ins_pct;
		int del_pct;
		ins_pct = (kind == PH_FILL) ? 75 : (kind == PH_DRAIN) ? 20 : 45;
		del_pct = (kind == PH_FILL) ? 10 : (kind == PH_DRAIN) ? 60 : 25;
		in_phase = 1'b1;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
			else if (roll < 4 + ins_pct)
				mode = MODE_W'($urandom_range(MODE_INS_FRONT, MODE_INS_POS));
			else if (roll < 4 + ins_pct + del_pct)
				mode = MODE_DELETE;
			else
				mode = MODE_SEARCH;
			value = pick_value(mode == MODE_DELETE || mode == MODE_SEARCH);
			if (mode == MODE_INS_POS && $urandom_range(0, 4) != 0)
				pos = POS_W'($urandom_range(0, list_len));
			else
				pos = POS_W'($urandom_range(0, 31));
			pace_sender();
			push_request(mode, value, pos, 1'b0, '0);
		end
		in_phase = 1'b0;
	endtask

	initial begin : rsp_pacing
		rx_mode_e seg_kind;
		int seg_left;
		int hold_left;
		bit hold_done;
		seg_kind = RX_OPEN;
		seg_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && in_phase && accepted_reqs >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_kind = rx_mode_e'($urandom_range(0, 2));
					seg_left = $urandom_range(10, 80);
				end
				seg_left--;
				case (seg_kind)
					RX_OPEN: rsp_if.ready <= 1'b1;
					RX_RANDOM: rsp_if.ready <= ($urandom_range(0, 3) != 0);
					default: rsp_if.ready <= (seg_left % 5 < 2);
				endcase
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		list_result_t want;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= REPORT_CAP)
					$error("response transaction with no request pending");
			end else begin
				want = pending_results.pop_front();
				status_hits[want.status]++;
				if (rsp_if.status !== want.status) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_CAP)
						$error("status: expected %0d, got %0d", want.status, rsp_if.status);
				end
				if (rsp_if.found_value !== want.found) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_CAP)
						$error("found_value: expected %h, got %h", want.found, rsp_if.found_value);
				end
				if (rsp_if.count !== want.count) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_CAP)
						$error("count: expected %0d, got %0d", want.count, rsp_if.count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stim
		int random_done;
		int phase_idx;
		int n;
		req_if.valid = 1'b0;
		req_if.mode = MODE_INS_FRONT;
		req_if.value = 32'sd0;
		req_if.position = 5'd0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(dir_plan); i++)
			for (int r = 0; r < dir_plan[i].reps; r++) begin
				pace_sender();
				push_request(dir_plan[i].mode, data_t'(dir_plan[i].value + r), dir_plan[i].pos,
					dir_plan[i].typed, dir_plan[i].want);
			end
		wait_for_results();

		random_done = 0;
		phase_idx = 0;
		while (random_done < RANDOM_ITEMS) begin
			n = $urandom_range(60, 140);
			run_phase(phase_kind_e'(phase_idx % 3), n);
			random_done += n;
			phase_idx++;
			wait_for_results();
		end

		repeat (16) @(posedge clk);
		$display("covered %0d requests over %0d random phases, peak list length %0d",
			accepted_reqs, phase_idx, peak_len);
		$display("statuses seen: ok %0d, full %0d, beyond count %0d, empty %0d, not found %0d",
			status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_RANGE],
			status_hits[ST_EMPTY], status_hits[ST_ABSENT]);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bole_pkg.sv
rtl/core/bole_ifs.sv
rtl/core/bole_cell.sv
rtl/core/bounded_ordered_list_engine.sv
tb/sv/tb.sv
